[hdl/max_rectangle_binary_matrix_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the maximal rectangle block
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MAX_RECTANGLE_BINARY_MATRIX_ASSERT_SVH
`define MAX_RECTANGLE_BINARY_MATRIX_ASSERT_SVH

// Same-cycle implication
`define MRBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrbm assertion failed");

// Next-cycle implication
`define MRBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrbm assertion failed");

`endif

[hdl/mrbm_pkg.sv]
// ----------------------------------------------------------------------------
// mrbm_pkg
// Types, constants and microcode for the maximal rectangle block.
// ----------------------------------------------------------------------------
package mrbm_pkg;

  localparam int ROW_WIDTH_W = 7;
  localparam int AREA_W      = 17;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int STEP_W      = 4;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 7'd64;
  localparam logic [AREA_W-1:0]      AREA_MAX      = 17'h1FFFF;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD,
    OP_POP,
    OP_MUL,
    OP_SCORE,
    OP_PUSH,
    OP_ENDROW,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_NO_POP,
    C_FLUSH,
    C_NOT_ROW_END,
    C_NOT_LAST,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic no_pop;
    logic flush;
    logic row_end;
    logic last;
    logic out_busy;
  } status_t;

  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_LOAD   = 4'd1;
  localparam step_t ST_TEST   = 4'd2;
  localparam step_t ST_POP    = 4'd3;
  localparam step_t ST_MUL    = 4'd4;
  localparam step_t ST_SCORE  = 4'd5;
  localparam step_t ST_TAIL   = 4'd6;
  localparam step_t ST_PUSH   = 4'd7;
  localparam step_t ST_RESCAN = 4'd8;
  localparam step_t ST_ENDROW = 4'd9;
  localparam step_t ST_WAIT   = 4'd10;
  localparam step_t ST_EMIT   = 4'd11;

  function automatic ucode_t ucode(input step_t s);
    ucode_t w;
    case (s)
      ST_IDLE:   w = '{op: OP_ACCEPT, cond: C_NO_INPUT,    target: ST_IDLE};
      ST_LOAD:   w = '{op: OP_LOAD,   cond: C_NEVER,       target: ST_IDLE};
      ST_TEST:   w = '{op: OP_NONE,   cond: C_NO_POP,      target: ST_TAIL};
      ST_POP:    w = '{op: OP_POP,    cond: C_NEVER,       target: ST_IDLE};
      ST_MUL:    w = '{op: OP_MUL,    cond: C_NEVER,       target: ST_IDLE};
      ST_SCORE:  w = '{op: OP_SCORE,  cond: C_ALWAYS,      target: ST_TEST};
      ST_TAIL:   w = '{op: OP_NONE,   cond: C_FLUSH,       target: ST_ENDROW};
      ST_PUSH:   w = '{op: OP_PUSH,   cond: C_NOT_ROW_END, target: ST_IDLE};
      ST_RESCAN: w = '{op: OP_NONE,   cond: C_ALWAYS,      target: ST_TEST};
      ST_ENDROW: w = '{op: OP_ENDROW, cond: C_NOT_LAST,    target: ST_IDLE};
      ST_WAIT:   w = '{op: OP_NONE,   cond: C_OUT_BUSY,    target: ST_WAIT};
      ST_EMIT:   w = '{op: OP_EMIT,   cond: C_ALWAYS,      target: ST_IDLE};
      default:   w = '{op: OP_NONE,   cond: C_ALWAYS,      target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

[hdl/mrbm_seq.sv]
// ----------------------------------------------------------------------------
// mrbm_seq
// Step counter and microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module mrbm_seq import mrbm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ucode_t  ctrl
);

  step_t step;
  step_t step_next;
  logic  taken;

  assign ctrl = ucode(step);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:       taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_NO_INPUT:    taken = !status.in_valid;
      C_NO_POP:      taken = status.no_pop;
      C_FLUSH:       taken = status.flush;
      C_NOT_ROW_END: taken = !status.row_end;
      C_NOT_LAST:    taken = !status.last;
      C_OUT_BUSY:    taken = status.out_busy;
      default:       taken = 1'b1;
    endcase
    step_next = taken ? ctrl.target : step + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[hdl/mrbm_dp.sv]
// ----------------------------------------------------------------------------
// mrbm_dp
// Datapath: column heights, index stack, area multiplier and best area.
// ----------------------------------------------------------------------------
module mrbm_dp import mrbm_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ucode_t                 ctrl,
  output status_t                status,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic                   cell_bit,
  input  logic                   last_cell,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [AREA_W-1:0]      max_area,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ROW_WIDTH_W-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int IW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int HW  = $clog2(MAX_ROWS + 1);
  localparam int WW  = (CW > ROW_WIDTH_W) ? CW : ROW_WIDTH_W;
  localparam int PW  = HW + CW;
  localparam int PXW = (PW > AREA_W) ? PW : AREA_W;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [HW-1:0] h;
  } entry_t;

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [CW-1:0]          eff_w;
  logic [WW-1:0]          rw_ext;
  logic [CW-1:0]          col_pos;
  logic [CW-1:0]          pos_c;
  logic [CW-1:0]          pos;
  logic [CW-1:0]          cmp_pos;
  logic                   bit_r;
  logic                   last_r;
  logic                   flush;
  logic [HW-1:0]          h_cell;
  logic [HW-1:0]          cmp_h;
  logic [HW-1:0]          h_old;
  logic [HW-1:0]          h_new;
  logic [HW-1:0]          top_h;
  logic [HW-1:0]          mul_a;
  logic [CW-1:0]          depth;
  logic [CW-1:0]          span;
  logic                   span_wrap;
  logic [PXW-1:0]         prod;
  logic [AREA_W-1:0]      score;
  logic [AREA_W-1:0]      best;
  logic [MAX_COLS-1:0]    hvalid;
  logic [HW-1:0]          hmem [MAX_COLS];
  logic [HW-1:0]          hrd;
  entry_t                 smem [MAX_COLS];
  entry_t                 srd;
  entry_t                 push_e;
  logic [IW-1:0]          s_raddr;
  logic                   accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (ctrl.op == OP_ACCEPT);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    rw_ext = WW'(row_width);
    if (row_width == '0) begin
      eff_w = CW'(1);
    end else if (rw_ext > WW'(MAX_COLS)) begin
      eff_w = CW'(MAX_COLS);
    end else begin
      eff_w = CW'(rw_ext);
    end
    pos_c = (col_pos >= eff_w) ? eff_w - CW'(1) : col_pos;

    h_old = hvalid[pos[IW-1:0]] ? hrd : '0;
    if (!bit_r) begin
      h_new = '0;
    end else if (HW'(h_old) < HW'(MAX_ROWS)) begin
      h_new = h_old + HW'(1);
    end else begin
      h_new = h_old;
    end

    top_h     = (CW'(srd.idx) == pos) ? h_cell : srd.h;
    span      = (depth == '0) ? cmp_pos : cmp_pos - CW'(srd.idx) - CW'(1);
    // bar below sits at or past the scoring position: the width wraps, saturate
    span_wrap = (depth != '0) && (cmp_pos <= CW'(srd.idx));
    score     = (prod > PXW'(AREA_MAX)) ? AREA_MAX : AREA_W'(prod);
    push_e    = '{idx: pos[IW-1:0], h: h_cell};
    s_raddr   = (ctrl.op == OP_LOAD) ? IW'(depth - CW'(1)) : IW'(depth - CW'(2));

    status.in_valid = s_axis_tvalid;
    status.no_pop   = (depth == '0) || !(cmp_h < top_h);
    status.flush    = flush;
    status.row_end  = ((pos + CW'(1)) >= eff_w) || last_r;
    status.last     = last_r;
    status.out_busy = m_axis_tvalid && !m_axis_tready;
  end

  // column height store
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_LOAD) begin
      hmem[pos[IW-1:0]] <= h_new;
    end
    hrd <= hmem[pos_c[IW-1:0]];
  end

  // index stack store, read data doubles as the cached top
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_PUSH) begin
      smem[depth[IW-1:0]] <= push_e;
      srd                 <= push_e;
    end else if (ctrl.op == OP_LOAD || ctrl.op == OP_POP) begin
      srd <= smem[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width     <= ROW_WIDTH_RST;
      col_pos       <= '0;
      depth         <= '0;
      flush         <= 1'b0;
      best          <= '0;
      hvalid        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        row_width <= cfg_data;
      end
      if (ctrl.op == OP_EMIT) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (ctrl.op)
        OP_LOAD: begin
          hvalid[pos[IW-1:0]] <= 1'b1;
        end
        OP_POP: begin
          depth <= depth - CW'(1);
        end
        OP_SCORE: begin
          if (score > best) begin
            best <= score;
          end
        end
        OP_PUSH: begin
          depth <= depth + CW'(1);
          if (status.row_end) begin
            flush <= 1'b1;
          end else begin
            col_pos <= pos + CW'(1);
          end
        end
        OP_ENDROW: begin
          depth   <= '0;
          col_pos <= '0;
          flush   <= 1'b0;
        end
        OP_EMIT: begin
          best   <= '0;
          hvalid <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ACCEPT: begin
        if (accept) begin
          bit_r  <= cell_bit;
          last_r <= last_cell;
          pos    <= pos_c;
        end
      end
      OP_LOAD: begin
        h_cell  <= h_new;
        cmp_h   <= h_new;
        cmp_pos <= pos;
      end
      OP_POP: begin
        mul_a <= top_h;
      end
      OP_MUL: begin
        prod <= span_wrap ? PXW'(AREA_MAX) : PXW'(mul_a) * PXW'(span);
      end
      OP_PUSH: begin
        if (status.row_end) begin
          cmp_h   <= '0;
          cmp_pos <= pos + CW'(1);
        end
      end
      OP_EMIT: begin
        max_area <= best;
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/max_rectangle_binary_matrix.sv]
// ----------------------------------------------------------------------------
// max_rectangle_binary_matrix
// Largest all-ones rectangle of a streamed binary matrix.
// ----------------------------------------------------------------------------
// Cells arrive on the s_axis channel in row-major order, one per transfer,
// with tlast on the final cell of the matrix. The row width sits in a
// register written over the cfg channel (always ready); write it only while
// the block is idle. The m_axis channel carries one result, the largest area,
// after the transfer that carries tlast.
// Per cell the microcode sequencer runs idle (accept), load, test, tail and
// push; each bar popped off the index stack adds pop, multiply, score and
// test, a row end adds rescan, test, tail, end-of-row and the flush pops,
// and the last cell wait and emit to load the result. Pops are bounded by
// pushes. The stack's single read port and shared multiplier set this flow.
// Reset clears the column heights (per-column valid flags), the stack, the
// best area and the output valid flag, and sets the row width to 64.
// A stalled result holds m_axis; cells are still taken meanwhile, and only
// the next result waits until the held one is transferred.
// ----------------------------------------------------------------------------
module max_rectangle_binary_matrix import mrbm_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [0] cell_bit
  input  logic                   s_axis_tlast,  // last_cell
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [16:0] max_area
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ROW_WIDTH_W-1:0] cfg_data
);

  ucode_t            ctrl;
  status_t           status;
  logic [AREA_W-1:0] max_area;

  assign m_axis_tdata = {{(OUT_TDATA_W - AREA_W){1'b0}}, max_area};

  mrbm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  mrbm_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cell_bit      (s_axis_tdata[0]),
    .last_cell     (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .max_area      (max_area),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

endmodule

[hdl/mrbm_checker.sv]
// ----------------------------------------------------------------------------
// mrbm_checker
// Port-level checks on the maximal rectangle block, bound to the top level.
// ----------------------------------------------------------------------------
`include "max_rectangle_binary_matrix_assert.svh"

module mrbm_checker import mrbm_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   cfg_ready
);

  `MRBM_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)
  `MRBM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `MRBM_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `MRBM_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:AREA_W] == '0)

endmodule

bind max_rectangle_binary_matrix mrbm_checker u_mrbm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);
